FILE: rtl/core/jas_pkg.sv
// shared types and constants for the joystick axis scaler
// no dependencies; imported by every module of the block
`default_nettype none

package jas_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int OFFSET_W        = SAMPLE_W + 1;
    localparam int POS_W           = 8;
    localparam int DZ_W            = 5;
    localparam int QUO_W           = 7;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int CFG_IDX_W       = 3;

    localparam logic [SAMPLE_W-1:0] CENTER_RST  = 16'h0000;
    localparam logic [SAMPLE_W-1:0] MINIMUM_RST = 16'h8001;
    localparam logic [SAMPLE_W-1:0] MAXIMUM_RST = 16'h7fff;

    localparam logic [POS_W-1:0] POS_MAX_MAG = 8'd127;
    localparam logic [POS_W-1:0] NEG_MAX_MAG = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS0_CENTER  = 3'd0,
        REG_AXIS0_MINIMUM = 3'd1,
        REG_AXIS0_MAXIMUM = 3'd2,
        REG_AXIS1_CENTER  = 3'd3,
        REG_AXIS1_MINIMUM = 3'd4,
        REG_AXIS1_MAXIMUM = 3'd5,
        REG_DEADZONE      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
    } axis_cal_t;

    typedef struct packed {
        axis_cal_t [1:0]  axis;
        logic [DZ_W-1:0]  deadzone;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rem;
        logic [SAMPLE_W-1:0] divisor;
        logic [QUO_W-1:0]    quo;
        logic                neg;
        logic                sat;
        logic                zero;
    } div_t;

endpackage

`default_nettype wire

FILE: rtl/core/jas_cfg.sv
// calibration and deadzone register file
// depends on jas_pkg
`default_nettype none

module jas_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [jas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [jas_pkg::SAMPLE_W-1:0]    cfg_data,
    output jas_pkg::cfg_t                        cfg
);
    import jas_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AXIS0_CENTER:  cfg_next.axis[0].center  = cfg_data;
                REG_AXIS0_MINIMUM: cfg_next.axis[0].minimum = cfg_data;
                REG_AXIS0_MAXIMUM: cfg_next.axis[0].maximum = cfg_data;
                REG_AXIS1_CENTER:  cfg_next.axis[1].center  = cfg_data;
                REG_AXIS1_MINIMUM: cfg_next.axis[1].minimum = cfg_data;
                REG_AXIS1_MAXIMUM: cfg_next.axis[1].maximum = cfg_data;
                REG_DEADZONE:      cfg_next.deadzone        = cfg_data[DZ_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis[0].center  <= CENTER_RST;
            cfg_reg.axis[0].minimum <= MINIMUM_RST;
            cfg_reg.axis[0].maximum <= MAXIMUM_RST;
            cfg_reg.axis[1].center  <= CENTER_RST;
            cfg_reg.axis[1].minimum <= MINIMUM_RST;
            cfg_reg.axis[1].maximum <= MAXIMUM_RST;
            cfg_reg.deadzone        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/jas_front.sv
// front end: offset from center, span select, magnitudes and saturation check
// two register stages; depends on jas_pkg
`default_nettype none

module jas_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire jas_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [jas_pkg::SAMPLE_W-1:0]  raw_sample,
    input  wire logic                          axis_select,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output jas_pkg::div_t                      out_data
);
    import jas_pkg::*;

    axis_cal_t cal;

    logic                       s1_valid_reg;
    logic                       s1_ready;
    logic signed [OFFSET_W-1:0] off_reg;
    logic signed [OFFSET_W-1:0] off_next;
    logic signed [OFFSET_W-1:0] span_neg_reg;
    logic signed [OFFSET_W-1:0] span_neg_next;
    logic signed [OFFSET_W-1:0] span_pos_reg;
    logic signed [OFFSET_W-1:0] span_pos_next;

    logic                       s2_valid_reg;
    logic                       s2_ready;
    logic signed [OFFSET_W-1:0] span;
    logic [OFFSET_W-1:0]        off_abs;
    logic [OFFSET_W-1:0]        span_abs;
    div_t                       s2_data_reg;
    div_t                       s2_data_next;

    // stage 1: pick calibration, three parallel subtractions
    assign cal = cfg.axis[axis_select];

    assign off_next      = $signed({raw_sample[SAMPLE_W-1], raw_sample})
                         - $signed({cal.center[SAMPLE_W-1], cal.center});
    assign span_neg_next = $signed({cal.center[SAMPLE_W-1], cal.center})
                         - $signed({cal.minimum[SAMPLE_W-1], cal.minimum});
    assign span_pos_next = $signed({cal.maximum[SAMPLE_W-1], cal.maximum})
                         - $signed({cal.center[SAMPLE_W-1], cal.center});

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            off_reg      <= off_next;
            span_neg_reg <= span_neg_next;
            span_pos_reg <= span_pos_next;
        end
    end

    // stage 2: span by sign of offset, magnitudes, quotient overflow check
    assign span     = off_reg[OFFSET_W-1] ? span_neg_reg : span_pos_reg;
    assign off_abs  = off_reg[OFFSET_W-1] ? OFFSET_W'(-off_reg) : OFFSET_W'(off_reg);
    assign span_abs = span[OFFSET_W-1] ? OFFSET_W'(-span) : OFFSET_W'(span);

    always_comb
    begin
        s2_data_next.rem     = off_abs[SAMPLE_W-1:0];
        s2_data_next.divisor = span_abs[SAMPLE_W-1:0];
        s2_data_next.quo     = '0;
        s2_data_next.neg     = off_reg[OFFSET_W-1] ^ span[OFFSET_W-1];
        s2_data_next.zero    = (off_reg == '0) || (span == '0);
        s2_data_next.sat     = off_abs >= span_abs;
    end

    assign s2_ready = !s2_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/jas_div.sv
// pipelined restoring divider for the scaled magnitude, two quotient bits in each
// stage but the last, which takes one; depends on jas_pkg
`default_nettype none

module jas_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire jas_pkg::div_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output jas_pkg::div_t      out_data
);
    import jas_pkg::*;

    // one quotient bit: shift remainder, subtract divisor when it fits
    function automatic div_t div_step(input div_t d);
        div_t                r;
        logic [SAMPLE_W:0]   dbl;
        logic [SAMPLE_W:0]   diff;
        logic                ge;
        r    = d;
        dbl  = {d.rem, 1'b0};
        diff = dbl - {1'b0, d.divisor};
        ge   = dbl >= {1'b0, d.divisor};
        r.rem = ge ? diff[SAMPLE_W-1:0] : dbl[SAMPLE_W-1:0];
        r.quo = {d.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    div_t stage_in       [DIV_STAGES];
    logic stage_in_valid [DIV_STAGES];
    div_t stage_data_reg [DIV_STAGES];
    logic stage_valid_reg[DIV_STAGES];
    logic stage_ready    [DIV_STAGES];
    logic down_ready     [DIV_STAGES];

    assign stage_in[0]       = in_data;
    assign stage_in_valid[0] = in_valid;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int LEFT  = QUO_W - s * STEPS_PER_STAGE;
        localparam int NSTEP = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

        div_t data_next;

        if (s > 0)
        begin : g_link
            assign stage_in[s]       = stage_data_reg[s-1];
            assign stage_in_valid[s] = stage_valid_reg[s-1];
        end

        if (s == DIV_STAGES - 1)
        begin : g_last
            assign down_ready[s] = out_ready;
        end
        else
        begin : g_mid
            assign down_ready[s] = stage_ready[s+1];
        end

        assign stage_ready[s] = !stage_valid_reg[s] || down_ready[s];

        always_comb
        begin
            data_next = stage_in[s];
            for (int k = 0; k < NSTEP; k++)
            begin
                data_next = div_step(data_next);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                stage_valid_reg[s] <= stage_in_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_in_valid[s] && stage_ready[s])
            begin
                stage_data_reg[s] <= data_next;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = stage_valid_reg[DIV_STAGES-1];
    assign out_data  = stage_data_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/jas_back.sv
// back end: clamp, deadzone, sign and the output register
// depends on jas_pkg
`default_nettype none

module jas_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [jas_pkg::DZ_W-1:0]   deadzone,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire jas_pkg::div_t              in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [jas_pkg::POS_W-1:0]       scaled_position
);
    import jas_pkg::*;

    logic [POS_W-1:0] dz;
    logic [POS_W-1:0] mag;
    logic [POS_W-1:0] mag_dz;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             valid_reg;

    // half width of the zone is six steps per deadzone unit
    assign dz = (POS_W'(deadzone) << 2) + (POS_W'(deadzone) << 1);

    always_comb
    begin
        if (in_data.zero)
        begin
            mag = '0;
        end
        else if (in_data.sat)
        begin
            mag = in_data.neg ? NEG_MAX_MAG : POS_MAX_MAG;
        end
        else
        begin
            mag = {1'b0, in_data.quo};
        end
        mag_dz   = (mag < dz) ? '0 : mag;
        pos_next = in_data.neg ? POS_W'(-mag_dz) : mag_dz;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pos_reg <= pos_next;
        end
    end

    assign out_valid       = valid_reg;
    assign scaled_position = pos_reg;

endmodule

`default_nettype wire

FILE: rtl/core/joystick_axis_scaler.sv
// joystick axis scaler top level: register file, front end, divider, back end
// depends on jas_pkg, jas_cfg, jas_front, jas_div, jas_back
//
// usage
//   input channel in_valid/in_ready carries raw_sample and axis_select; each
//   request gives one scaled_position on the out_valid/out_ready channel, in
//   order. calibration and deadzone are set through cfg_we/cfg_index/cfg_data
//   while no request is in flight; an index of 7 is ignored
//   seven register stages: two front end stages, four divider stages (two
//   quotient bits each, one in the last) and the output register
//   a request can enter every cycle, one result per cycle while the receiver
//   keeps out_ready high
//   when out_ready is low the output register holds its result and requests
//   keep entering until every stage is full, then in_ready drops; nothing is
//   lost or repeated
//   reset clears all stage valid bits and loads the calibration defaults:
//   center 0, minimum -32767, maximum 32767, deadzone 0
`default_nettype none

module joystick_axis_scaler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [jas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [jas_pkg::SAMPLE_W-1:0]  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [jas_pkg::SAMPLE_W-1:0]  raw_sample,
    input  wire logic                         axis_select,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [jas_pkg::POS_W-1:0]          scaled_position
);
    import jas_pkg::*;

    cfg_t cfg;
    logic front_valid;
    logic div_ready;
    div_t front_data;
    logic div_valid;
    logic back_ready;
    div_t div_data;

    jas_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jas_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .raw_sample  (raw_sample),
        .axis_select (axis_select),
        .out_valid   (front_valid),
        .out_ready   (div_ready),
        .out_data    (front_data)
    );

    jas_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (div_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (back_ready),
        .out_data  (div_data)
    );

    jas_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .deadzone        (cfg.deadzone),
        .in_valid        (div_valid),
        .in_ready        (back_ready),
        .in_data         (div_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .scaled_position (scaled_position)
    );

endmodule

`default_nettype wire

FILE: rtl/core/jas_checker.sv
// port level checks for the joystick axis scaler, bound to the top level
// depends on jas_pkg and joystick_axis_scaler
`default_nettype none

module jas_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [jas_pkg::POS_W-1:0]     scaled_position
);
    import jas_pkg::*;

    // stalled result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scaled_position))
        else $error("stalled result changed or dropped");

    // a free output register frees the whole pipeline
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output side is free");

    // no result right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

    // a result needs an earlier request; checked only just after reset
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !out_valid)
        else $error("result appeared without a request");

endmodule

bind joystick_axis_scaler jas_checker u_jas_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .scaled_position (scaled_position)
);

`default_nettype wire

FILE: bench/joystick_axis_scaler_test.sv
// self-checking testbench for the joystick axis scaler: predicts each scaled position
// from its own copy of the calibration and compares every result in order
// depends on jas_pkg and joystick_axis_scaler
module joystick_axis_scaler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jas_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int SCALE_FACTOR   = 128;
    localparam int POS_LOW        = -128;
    localparam int POS_HIGH       = 127;
    localparam int ZONE_STEP      = 6;
    localparam int DRAIN_PAUSE    = 10;
    localparam int END_PAUSE      = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_SAMPLES  = 120;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SAMPLE_W-1:0]   cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   raw_sample = '0;
    logic                  axis_select = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [POS_W-1:0]      scaled_position;

    logic signed [SAMPLE_W-1:0] cal_center  [2] = '{16'sd0, 16'sd0};
    logic signed [SAMPLE_W-1:0] cal_minimum [2] = '{-16'sd32767, -16'sd32767};
    logic signed [SAMPLE_W-1:0] cal_maximum [2] = '{16'sd32767, 16'sd32767};
    logic [DZ_W-1:0]            dz_level = '0;

    logic [POS_W-1:0] expected_positions [$];
    int samples_sent = 0;
    int positions_checked = 0;
    int settings_applied = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    joystick_axis_scaler i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_sample     (raw_sample),
        .axis_select    (axis_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scaled_position(scaled_position)
    );

    always #5 clk = ~clk;

    function automatic logic [POS_W-1:0] predict_position(logic [SAMPLE_W-1:0] raw, logic sel);
        int offset;
        int span;
        int pos;
        int zone;
        offset = int'($signed(raw)) - int'(cal_center[sel]);
        if (offset < 0)
            span = int'(cal_center[sel]) - int'(cal_minimum[sel]);
        else if (offset > 0)
            span = int'(cal_maximum[sel]) - int'(cal_center[sel]);
        else
            span = 0;
        pos = (span != 0) ? (offset * SCALE_FACTOR) / span : 0;
        if (pos < POS_LOW)
            pos = POS_LOW;
        if (pos > POS_HIGH)
            pos = POS_HIGH;
        zone = int'(dz_level) * ZONE_STEP;
        if (pos > -zone && pos < zone)
            pos = 0;
        return pos[POS_W-1:0];
    endfunction

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_positions.size() == 0)
            begin
                $error("scaled_position unexpected result %0d", $signed(scaled_position));
                mismatches++;
            end
            else
            begin
                if (scaled_position !== expected_positions[0])
                begin
                    $error("scaled_position expected %0d actual %0d",
                           $signed(expected_positions[0]), $signed(scaled_position));
                    mismatches++;
                end
                void'(expected_positions.pop_front());
                positions_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic sel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        raw_sample  <= raw;
        axis_select <= sel;
        do
            @(posedge clk);
        while (!in_ready);
        expected_positions.push_back(predict_position(raw, sel));
        samples_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_AXIS0_CENTER:  cal_center[0]  = data;
            REG_AXIS0_MINIMUM: cal_minimum[0] = data;
            REG_AXIS0_MAXIMUM: cal_maximum[0] = data;
            REG_AXIS1_CENTER:  cal_center[1]  = data;
            REG_AXIS1_MINIMUM: cal_minimum[1] = data;
            REG_AXIS1_MAXIMUM: cal_maximum[1] = data;
            REG_DEADZONE:      dz_level       = data[DZ_W-1:0];
            default:           ;
        endcase
    endtask

    task automatic calibrate(input int c0, input int lo0, input int hi0,
                             input int c1, input int lo1, input int hi1, input int dz);
        logic [SAMPLE_W-1:0] dz_word;
        wait_for_drain();
        dz_word = 16'($urandom());
        dz_word[DZ_W-1:0] = DZ_W'(dz);
        write_reg(REG_AXIS0_CENTER, 16'(c0));
        write_reg(REG_AXIS0_MINIMUM, 16'(lo0));
        write_reg(REG_AXIS0_MAXIMUM, 16'(hi0));
        write_reg(REG_AXIS1_CENTER, 16'(c1));
        write_reg(REG_AXIS1_MINIMUM, 16'(lo1));
        write_reg(REG_AXIS1_MAXIMUM, 16'(hi1));
        write_reg(REG_DEADZONE, dz_word);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32767, 1'b1);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd255, 1'b0);
        send_sample(-16'sd256, 1'b1);
    endtask

    task automatic test_extreme_calibration();
        calibrate(32767, -32768, 32767, -32768, -32768, 32767, 0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        send_sample(16'sd0, 1'b1);
    endtask

    task automatic test_inverted_and_flat();
        // axis zero inverted, axis one with no span at all
        calibrate(0, 100, -100, 500, 500, 500, 0);
        send_sample(16'sd50, 1'b0);
        send_sample(-16'sd50, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd600, 1'b1);
        send_sample(16'sd400, 1'b1);
        send_sample(16'sd500, 1'b1);
    endtask

    task automatic test_deadzone();
        calibrate(0, -32767, 32767, 0, -32767, 32767, 31);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        calibrate(0, -32767, 32767, 0, -32767, 32767, 1);
        // unknown index must leave the deadzone alone
        write_reg(REG_NONE, 16'hffff);
        @(negedge clk);
        cfg_we <= 1'b0;
        send_sample(16'sd1280, 1'b0);
        send_sample(16'sd1536, 1'b1);
        send_sample(-16'sd1536, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        repeat (40)
            send_sample(16'($urandom()), 1'($urandom_range(1)));
        wait_for_drain();
    endtask

    task automatic random_calibration();
        int v [3];
        int tmp;
        int c [2];
        int lo [2];
        int hi [2];
        for (int a = 0; a < 2; a++)
        begin
            for (int k = 0; k < 3; k++)
                v[k] = int'($signed(16'($urandom())));
            for (int k = 0; k < 2; k++)
                for (int j = 0; j < 2 - k; j++)
                    if (v[j] > v[j+1])
                    begin
                        tmp = v[j];
                        v[j] = v[j+1];
                        v[j+1] = tmp;
                    end
            c[a] = v[1];
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    lo[a] = v[0];
                    hi[a] = v[2];
                end
                6:
                begin
                    lo[a] = v[2];
                    hi[a] = v[0];
                end
                7:
                begin
                    lo[a] = v[1];
                    hi[a] = v[1];
                end
                8:
                begin
                    lo[a] = v[2];
                    hi[a] = v[0] ^ v[2];
                end
                default:
                begin
                    lo[a] = -32768;
                    hi[a] = 32767;
                end
            endcase
        end
        calibrate(c[0], lo[0], hi[0], c[1], lo[1], hi[1],
                  ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3));
    endtask

    task automatic send_random_sample();
        logic                sel;
        logic [SAMPLE_W-1:0] raw;
        sel = 1'($urandom_range(1));
        case ($urandom_range(9))
            0, 1, 2, 3: raw = 16'($urandom());
            4, 5, 6:    raw = 16'(int'(cal_center[sel]) + int'($urandom_range(4000)) - 2000);
            7:          raw = cal_center[sel];
            8:          raw = 16'(int'(cal_minimum[sel]) + int'($urandom_range(200)) - 100);
            default:    raw = 16'(int'(cal_maximum[sel]) + int'($urandom_range(200)) - 100);
        endcase
        send_sample(raw, sel);
    endtask

    task automatic test_random_phase(input int sender_pct, input int receiver_pct);
        random_calibration();
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        repeat (PHASE_SAMPLES)
            send_random_sample();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_extreme_calibration();
        test_inverted_and_flat();
        test_deadzone();
        test_backpressure();
        for (int round = 0; round < 2; round++)
        begin
            test_random_phase(0, 0);
            test_random_phase(53, 0);
            test_random_phase(0, 53);
            test_random_phase(17, 17);
        end

        wait_for_drain();
        repeat (END_PAUSE) @(posedge clk);
        $display("%0d samples sent, %0d positions checked, %0d calibration settings",
                 samples_sent, positions_checked, settings_applied);
        $display("covered inverted and flat spans, deadzone extremes, backpressure and idling");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/jas_pkg.sv
rtl/core/jas_cfg.sv
rtl/core/jas_front.sv
rtl/core/jas_div.sv
rtl/core/jas_back.sv
rtl/core/joystick_axis_scaler.sv
rtl/core/jas_checker.sv
bench/joystick_axis_scaler_test.sv
